// File: sv/sorted_insert_list_top_defines.svh
// Assertion macros shared by the sorted insert list checker.
`ifndef SORTED_INSERT_LIST_TOP_DEFINES_SVH
`define SORTED_INSERT_LIST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define SIL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define SIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sil_pkg.sv
// Types and codes shared by the sorted insert list modules.
package sil_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ELEMENT  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

// File: sv/sil_cell.sv
// One storage cell of the sorted chain: compare, shift on insert, rotate on dump.
module sil_cell #(
    parameter int CAPACITY = 16,
    parameter int IDX      = 0
) (
    input  logic                                 i_clk,
    input  sil_pkg::t_cell_ctl                   i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]        i_count,
    input  logic                                 i_prev_lt,
    input  logic signed [sil_pkg::DATA_W-1:0]    i_prev_val,
    input  logic signed [sil_pkg::DATA_W-1:0]    i_next_val,
    output logic                                 o_lt,
    output logic signed [sil_pkg::DATA_W-1:0]    o_val
);

    localparam int CW = $clog2(CAPACITY+1);

    logic signed [sil_pkg::DATA_W-1:0] r_val;
    logic signed [sil_pkg::DATA_W-1:0] n_val;
    logic                              occupied;

    assign occupied = (CW'(IDX) < i_count);
    // A cell stays put when it holds a value smaller than the new one.
    assign o_lt     = occupied && (r_val < i_ctl.value);
    assign o_val    = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            sil_pkg::CELL_INSERT: begin
                if (!o_lt) begin
                    n_val = i_prev_lt ? i_ctl.value : i_prev_val;
                end
            end
            sil_pkg::CELL_ROTATE: begin
                n_val = i_next_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: sv/sorted_insert_list_top.sv
// Insert: result registered in the cycle after the input transfer; one insert can be taken
// every cycle while the output slot is free and no dump runs. Dump: the cell ring rotates
// CAPACITY times, once per cycle unless an output stall holds it, and streams the n stored
// values in the first n rotations. An empty dump answers, like an insert, in the cycle after.
// Reset clears the entry count, the sequencer and the output valid; cell contents are
// undefined until written and are never shown before that.
module sorted_insert_list_top #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_action,
    input  logic signed [sil_pkg::DATA_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic signed [sil_pkg::DATA_W-1:0]  o_item_value,
    output logic [sil_pkg::INDEX_W-1:0]        o_item_index,
    output logic                               o_last
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam int SW = $clog2(CAPACITY);
    localparam int IW = sil_pkg::INDEX_W;
    localparam int DW = sil_pkg::DATA_W;

    sil_pkg::t_state   r_state;
    sil_pkg::t_state   n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [SW-1:0]     r_step;
    logic [SW-1:0]     n_step;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic signed [DW-1:0] r_item_value;
    logic signed [DW-1:0] n_item_value;
    logic [IW-1:0]     r_item_index;
    logic [IW-1:0]     n_item_index;
    logic              r_last;
    logic              n_last;

    logic              slot_free;
    logic              in_take;
    logic              full;
    logic              emit_now;
    logic              advance;
    logic              load;
    sil_pkg::t_cell_ctl cell_ctl;

    logic                 lt  [CAPACITY];
    logic signed [DW-1:0] val [CAPACITY];

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != sil_pkg::S_IDLE) || !slot_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(CAPACITY));
    // During a dump the ring keeps turning after the last stored value until it is aligned.
    assign emit_now   = (r_state == sil_pkg::S_DUMP) && (CW'(r_step) < r_count);
    assign advance    = (r_state == sil_pkg::S_DUMP) && (!emit_now || slot_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            sil_pkg::S_IDLE: begin
                if (in_take && (i_action == sil_pkg::ACT_DUMP) && (r_count != '0)) begin
                    n_state = sil_pkg::S_DUMP;
                end
            end
            sil_pkg::S_DUMP: begin
                if (advance && (r_step == SW'(CAPACITY - 1))) begin
                    n_state = sil_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sil_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cell_ctl.op    = sil_pkg::CELL_HOLD;
        cell_ctl.value = i_value;
        load           = 1'b0;
        n_status       = r_status;
        n_item_value   = r_item_value;
        n_item_index   = r_item_index;
        n_last         = r_last;
        n_count        = r_count;
        n_step         = '0;
        case (r_state)
            sil_pkg::S_IDLE: begin
                if (in_take) begin
                    if (i_action == sil_pkg::ACT_INSERT) begin
                        load         = 1'b1;
                        n_item_value = i_value;
                        n_item_index = '0;
                        n_last       = 1'b1;
                        if (full) begin
                            n_status = sil_pkg::ST_FULL;
                        end else begin
                            n_status    = sil_pkg::ST_INSERTED;
                            cell_ctl.op = sil_pkg::CELL_INSERT;
                            n_count     = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        load         = 1'b1;
                        n_status     = sil_pkg::ST_EMPTY;
                        n_item_value = '0;
                        n_item_index = '0;
                        n_last       = 1'b1;
                    end
                end
            end
            sil_pkg::S_DUMP: begin
                n_step = r_step;
                if (advance) begin
                    cell_ctl.op = sil_pkg::CELL_ROTATE;
                    n_step      = r_step + SW'(1);
                    if (emit_now) begin
                        load         = 1'b1;
                        n_status     = sil_pkg::ST_ELEMENT;
                        n_item_value = val[0];
                        n_item_index = IW'(r_step);
                        n_last       = ((CW'(r_step) + CW'(1)) == r_count);
                    end
                end
            end
            default: begin
                n_step = '0;
            end
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sil_pkg::S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status     <= n_status;
            r_item_value <= n_item_value;
            r_item_index <= n_item_index;
            r_last       <= n_last;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                 prev_lt;
            logic signed [DW-1:0] prev_val;
            if (g == 0) begin : g_head
                // The head cell takes the new value whenever it does not keep its own.
                assign prev_lt  = 1'b1;
                assign prev_val = val[0];
            end else begin : g_body
                assign prev_lt  = lt[g-1];
                assign prev_val = val[g-1];
            end
            sil_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_count    (r_count),
                .i_prev_lt  (prev_lt),
                .i_prev_val (prev_val),
                .i_next_val (val[(g + 1) % CAPACITY]),
                .o_lt       (lt[g]),
                .o_val      (val[g])
            );
        end
    endgenerate

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_item_value = r_item_value;
    assign o_item_index = r_item_index;
    assign o_last       = r_last;

endmodule

// File: sv/sil_checker.sv
// Port-level checks of the sorted insert list and their binding to the top level.
`include "sorted_insert_list_top_defines.svh"

module sil_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_action,
    input logic signed [sil_pkg::DATA_W-1:0]  i_value,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [1:0]                         o_status,
    input logic signed [sil_pkg::DATA_W-1:0]  o_item_value,
    input logic [sil_pkg::INDEX_W-1:0]        o_item_index,
    input logic                               o_last
);

    // A stalled result must stay in place until its transfer.
    `SIL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_item_value) && $stable(o_status) && $stable(o_last), "stalled result changed")

    // New input is refused while the output slot is still occupied and stalled.
    `SIL_ASSERT_IMPLY(a_in_blocked, o_out_valid && i_out_stall, o_in_stall, "input taken while output blocked")

    // Every insert answers in the next cycle with an echo of its value.
    `SIL_ASSERT_NEXT(a_insert_ack, i_in_valid && !o_in_stall && (i_action == sil_pkg::ACT_INSERT), o_out_valid && (o_item_value == $past(i_value)) && (o_status == sil_pkg::ST_INSERTED || o_status == sil_pkg::ST_FULL), "insert not acknowledged")

    // Single-result answers carry index zero and the last mark.
    `SIL_ASSERT_IMPLY(a_single_last, o_out_valid && (o_status == sil_pkg::ST_INSERTED || o_status == sil_pkg::ST_FULL || o_status == sil_pkg::ST_EMPTY), o_last && (o_item_index == '0), "single result not marked last")

endmodule

bind sorted_insert_list_top sil_checker u_sil_checker (.*);

// File: sim/tb.sv
// Self-checking testbench for sorted_insert_list_top with directed and random inserts and dumps.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW           = sil_pkg::DATA_W;
    localparam int IW           = sil_pkg::INDEX_W;
    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 370;
    localparam int IDLE_PCT     = 23;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_START   = 700;
    localparam int HOLD_CYCLES  = 120;
    localparam int CALM_FIRST   = 1200;
    localparam int CALM_LAST    = 1600;

    localparam logic signed [DW-1:0] CORNER_VALUES [5] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001
    };

    typedef struct packed {
        logic                       action;
        logic signed [DW-1:0]       value;
    } t_request;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [DW-1:0]       value;
        logic [IW-1:0]              index;
        logic                       last;
    } t_answer;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_action = sil_pkg::ACT_INSERT;
    logic signed [DW-1:0]       i_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [1:0]                 o_status;
    logic signed [DW-1:0]       o_item_value;
    logic [IW-1:0]              o_item_index;
    logic                       o_last;

    t_request                   request_queue[$];
    t_answer                    awaited_results[$];
    logic signed [DW-1:0]       shadow_list [CAPACITY];
    int                         shadow_count = 0;
    int unsigned                error_count = 0;
    int unsigned                quiet_cycles = 0;
    int unsigned                tx_cycles = 0;
    int unsigned                rx_cycles = 0;
    int unsigned                hold_left = 0;
    bit                         request_taken = 1'b0;

    sorted_insert_list_top #(
        .CAPACITY(CAPACITY)
    ) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Updates the shadow list for one accepted request and queues the answers it causes.
    task automatic predict_list_item(input logic action, input logic signed [DW-1:0] value);
        t_answer ans;
        int      pos;
        int      k;
        ans.status = sil_pkg::ST_INSERTED;
        ans.value  = value;
        ans.index  = '0;
        ans.last   = 1'b1;
        if (action == sil_pkg::ACT_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                ans.status = sil_pkg::ST_FULL;
            end else begin
                // Equal values go ahead of the ones already stored.
                pos = 0;
                while (pos < shadow_count && shadow_list[pos] < value) begin
                    pos++;
                end
                for (k = shadow_count; k > pos; k--) begin
                    shadow_list[k] = shadow_list[k-1];
                end
                shadow_list[pos] = value;
                shadow_count++;
            end
            awaited_results.push_back(ans);
        end else if (shadow_count == 0) begin
            ans.status = sil_pkg::ST_EMPTY;
            ans.value  = '0;
            awaited_results.push_back(ans);
        end else begin
            for (k = 0; k < shadow_count; k++) begin
                ans.status = sil_pkg::ST_ELEMENT;
                ans.value  = shadow_list[k];
                ans.index  = IW'(k);
                ans.last   = (k == shadow_count - 1);
                awaited_results.push_back(ans);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_request(input logic action, input logic signed [DW-1:0] value);
        t_request req;
        req.action = action;
        req.value  = value;
        request_queue.push_back(req);
    endtask

    function automatic logic signed [DW-1:0] random_value();
        logic signed [DW-1:0] v;
        case ($urandom_range(9))
            0: v = CORNER_VALUES[$urandom_range(4)];
            // A narrow range makes duplicates of stored values common.
            1, 2, 3: v = int'($urandom_range(16)) - 8;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_list_item(i_action, i_value);
                request_taken = 1'b1;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual status %0d value %0h",
                             $time, o_status, o_item_value);
                    error_count++;
                end else begin
                    exp_ans = awaited_results.pop_front();
                    check_field("status", DW'(exp_ans.status), DW'(o_status));
                    check_field("item_value", exp_ans.value, o_item_value);
                    check_field("item_index", DW'(exp_ans.index), DW'(o_item_index));
                    check_field("last", DW'(exp_ans.last), DW'(o_last));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Driver: offers the next request once the current one has been transferred.
    always @(negedge i_clk) begin
        t_request req;
        bit       calm;
        if (i_rst_n) begin
            tx_cycles++;
            calm = (tx_cycles >= CALM_FIRST && tx_cycles < CALM_LAST);
            if (!i_in_valid || request_taken) begin
                request_taken = 1'b0;
                if (request_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    req = request_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_action   <= req.action;
                    i_value    <= req.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off so the block backs up, and a calm stretch.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            rx_cycles++;
            if (rx_cycles == HOLD_START) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_cycles >= CALM_FIRST && rx_cycles < CALM_LAST) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        // Directed part: empty dump, extreme and duplicate values, then a dump.
        queue_request(sil_pkg::ACT_DUMP, 32'sh5A5A_5A5A);
        queue_request(sil_pkg::ACT_INSERT, 32'sh0000_0000);
        queue_request(sil_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
        queue_request(sil_pkg::ACT_INSERT, 32'sh8000_0000);
        queue_request(sil_pkg::ACT_INSERT, 32'shFFFF_FFFF);
        queue_request(sil_pkg::ACT_INSERT, 32'sh0000_0001);
        queue_request(sil_pkg::ACT_INSERT, 32'sh0000_0000);
        queue_request(sil_pkg::ACT_INSERT, 32'sh8000_0000);
        queue_request(sil_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
        queue_request(sil_pkg::ACT_DUMP, 32'shA5A5_A5A5);

        repeat (RANDOM_ITEMS) begin
            queue_request(($urandom_range(99) < 25) ? sil_pkg::ACT_DUMP : sil_pkg::ACT_INSERT,
                          random_value());
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() > 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (awaited_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (CAPACITY + 4) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
